[src/plc_pkg.sv]
`default_nettype none
package plc_pkg;

    localparam int CAPACITY  = 256;
    localparam int ITEM_BITS = 16;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 9;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    // result gather tree: groups of GRP cells
    localparam int GRP       = 16;
    localparam int NGRP      = (CAPACITY + GRP - 1) / GRP;

    localparam logic [2:0] ACT_INS_HEAD = 3'd0;
    localparam logic [2:0] ACT_INS_TAIL = 3'd1;
    localparam logic [2:0] ACT_INS_AT   = 3'd2;
    localparam logic [2:0] ACT_REM_HEAD = 3'd3;
    localparam logic [2:0] ACT_REM_TAIL = 3'd4;
    localparam logic [2:0] ACT_REM_AT   = 3'd5;
    localparam logic [2:0] ACT_READ     = 3'd6;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic                 sel;
        logic [ADDR_W-1:0]    at;
        logic [ITEM_BITS-1:0] item;
    } cell_ctrl_t;

endpackage
`default_nettype wire

[src/plc_cell.sv]
`default_nettype none
module plc_cell (
    input  wire logic                           aclk,
    input  wire plc_pkg::cell_ctrl_t            ctrl,
    input  wire logic [plc_pkg::ADDR_W-1:0]     idx,
    input  wire logic [plc_pkg::ITEM_BITS-1:0]  left_data,
    input  wire logic [plc_pkg::ITEM_BITS-1:0]  right_data,
    output logic      [plc_pkg::ITEM_BITS-1:0]  data,
    output logic      [plc_pkg::ITEM_BITS-1:0]  hit_data
);

    logic [plc_pkg::ITEM_BITS-1:0] data_reg;
    logic [plc_pkg::ITEM_BITS-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins && idx > ctrl.at) begin
            data_next = left_data;
        end else if (ctrl.ins && idx == ctrl.at) begin
            data_next = ctrl.item;
        end else if (ctrl.rem && idx >= ctrl.at) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // old contents, before this cycle's shift
    assign hit_data = (ctrl.sel && idx == ctrl.at) ? data_reg : '0;

endmodule
`default_nettype wire

[src/plc_gather.sv]
`default_nettype none
module plc_gather (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic [plc_pkg::ITEM_BITS-1:0]  hit_data [plc_pkg::CAPACITY],
    output logic      [plc_pkg::ITEM_BITS-1:0]  result
);

    localparam int PAD = plc_pkg::NGRP * plc_pkg::GRP;

    logic [plc_pkg::ITEM_BITS-1:0] padded [PAD];
    logic [plc_pkg::ITEM_BITS-1:0] grp_reg  [plc_pkg::NGRP];
    logic [plc_pkg::ITEM_BITS-1:0] grp_next [plc_pkg::NGRP];

    genvar i, g;
    generate
        for (i = 0; i < PAD; i++) begin : g_pad
            if (i < plc_pkg::CAPACITY) begin : g_real
                assign padded[i] = hit_data[i];
            end else begin : g_zero
                assign padded[i] = '0;
            end
        end
        for (g = 0; g < plc_pkg::NGRP; g++) begin : g_grp
            always_comb begin
                grp_next[g] = '0;
                for (int k = 0; k < plc_pkg::GRP; k++) begin
                    grp_next[g] = grp_next[g] | padded[g * plc_pkg::GRP + k];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    grp_reg[g] <= grp_next[g];
                end
            end
        end
    endgenerate

    always_comb begin
        result = '0;
        for (int k = 0; k < plc_pkg::NGRP; k++) begin
            result = result | grp_reg[k];
        end
    end

endmodule
`default_nettype wire

[src/positional_list_insert_remove.sv]
// Positional list: an ordered list of up to 256 16-bit identifiers.
// Commands arrive on the s_ channel (action, position, item_id); each gives
// exactly one result on the m_ channel (status, result_item, element_total).
// The list lives in a row of cells, cell 0 being the head. An insert shifts
// every cell at or after the index one place towards the tail at once, and a
// remove shifts the later cells one place towards the head.
// Timing: a command is taken into the command registers, the cells shift in
// the exec state while the removed or read entry is picked by a registered
// OR tree, and the result is loaded into the output register in the collect
// state once that register is free. One command is in flight at a time, so
// the next is taken only once the last result is in the output register.
// The output register lets the next command be taken while a result waits.
// If the receiver stalls, a finished result holds the tree stage until the
// output register frees up; s_tready stays low meanwhile.
// Reset (aresetn low, synchronous) empties the list and drops any result
// in flight; cell contents are left as they are and are never read when
// outside the count.
`default_nettype none
module positional_list_insert_remove (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // action[2:0], position[11:3], item_id[27:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // status[1:0], result_item[17:2], element_total[26:18]
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_COLLECT = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [plc_pkg::CNT_W-1:0] count_reg, count_next;

    logic                           cmd_ins_reg, cmd_rem_reg, cmd_rd_reg;
    logic [plc_pkg::ADDR_W-1:0]     cmd_at_reg;
    logic [plc_pkg::ITEM_BITS-1:0]  cmd_item_reg;
    logic [1:0]                     cmd_status_reg;

    logic                           m_valid_reg;
    logic [1:0]                     m_status_reg;
    logic [plc_pkg::ITEM_BITS-1:0]  m_item_reg;
    logic [plc_pkg::CNT_W-1:0]      m_total_reg;

    // decode
    logic [2:0]                     s_action;
    logic [plc_pkg::POS_W-1:0]      s_position;
    logic [plc_pkg::ITEM_BITS-1:0]  s_item;
    logic [plc_pkg::CMP_W-1:0]      cnt_x, pos_x, at_x;
    logic                           dec_ins, dec_rem, dec_rd;
    logic [1:0]                     dec_status;

    logic s_xfer, exec, out_free;

    assign s_action   = s_tdata[2:0];
    assign s_position = s_tdata[11:3];
    assign s_item     = s_tdata[12 +: plc_pkg::ITEM_BITS];
    assign cnt_x      = plc_pkg::CMP_W'(count_reg);
    assign pos_x      = plc_pkg::CMP_W'(s_position);

    always_comb begin
        dec_ins    = 1'b0;
        dec_rem    = 1'b0;
        dec_rd     = 1'b0;
        dec_status = plc_pkg::ST_IGNORED;
        at_x       = pos_x;
        unique case (s_action)
            plc_pkg::ACT_INS_HEAD, plc_pkg::ACT_INS_TAIL, plc_pkg::ACT_INS_AT: begin
                if (s_action == plc_pkg::ACT_INS_HEAD) begin
                    at_x = '0;
                end else if (s_action == plc_pkg::ACT_INS_TAIL) begin
                    at_x = cnt_x;
                end
                if (at_x > cnt_x) begin
                    dec_status = plc_pkg::ST_IGNORED;
                end else if (count_reg == plc_pkg::CNT_W'(plc_pkg::CAPACITY)) begin
                    dec_status = plc_pkg::ST_DROPPED;
                end else begin
                    dec_status = plc_pkg::ST_DONE;
                    dec_ins    = 1'b1;
                end
            end
            plc_pkg::ACT_REM_HEAD, plc_pkg::ACT_REM_TAIL, plc_pkg::ACT_REM_AT: begin
                if (s_action == plc_pkg::ACT_REM_HEAD) begin
                    at_x = '0;
                end else if (s_action == plc_pkg::ACT_REM_TAIL) begin
                    at_x = cnt_x - plc_pkg::CMP_W'(1);
                end
                if (count_reg == '0 || at_x >= cnt_x) begin
                    dec_status = plc_pkg::ST_IGNORED;
                end else begin
                    dec_status = plc_pkg::ST_DONE;
                    dec_rem    = 1'b1;
                end
            end
            plc_pkg::ACT_READ: begin
                if (pos_x < cnt_x) begin
                    dec_status = plc_pkg::ST_DONE;
                    dec_rd     = 1'b1;
                end
            end
            default: begin
                dec_status = plc_pkg::ST_IGNORED;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign exec     = (state_reg == S_EXEC);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_xfer) state_next = S_EXEC;
            S_EXEC:    state_next = S_COLLECT;
            S_COLLECT: if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (exec && cmd_ins_reg) begin
            count_next = count_reg + plc_pkg::CNT_W'(1);
        end else if (exec && cmd_rem_reg) begin
            count_next = count_reg - plc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmd_ins_reg <= 1'b0;
            cmd_rem_reg <= 1'b0;
            cmd_rd_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (s_xfer) begin
                cmd_ins_reg <= dec_ins;
                cmd_rem_reg <= dec_rem;
                cmd_rd_reg  <= dec_rd;
            end
            if (state_reg == S_COLLECT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    logic [plc_pkg::ITEM_BITS-1:0] gather_result;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_at_reg     <= at_x[plc_pkg::ADDR_W-1:0];
            cmd_item_reg   <= s_item;
            cmd_status_reg <= dec_status;
        end
        if (state_reg == S_COLLECT && out_free) begin
            m_status_reg <= cmd_status_reg;
            m_item_reg   <= gather_result;
            m_total_reg  <= count_reg;
        end
    end

    // cell row
    plc_pkg::cell_ctrl_t           ctrl;
    logic [plc_pkg::ITEM_BITS-1:0] cell_data [plc_pkg::CAPACITY];
    logic [plc_pkg::ITEM_BITS-1:0] hit_data  [plc_pkg::CAPACITY];

    assign ctrl.ins  = exec && cmd_ins_reg;
    assign ctrl.rem  = exec && cmd_rem_reg;
    assign ctrl.sel  = exec && (cmd_rem_reg || cmd_rd_reg);
    assign ctrl.at   = cmd_at_reg;
    assign ctrl.item = cmd_item_reg;

    genvar i;
    generate
        for (i = 0; i < plc_pkg::CAPACITY; i++) begin : g_cell
            logic [plc_pkg::ITEM_BITS-1:0] left_d, right_d;
            if (i == 0) begin : g_head
                assign left_d = '0;
            end else begin : g_mid_l
                assign left_d = cell_data[i-1];
            end
            if (i == plc_pkg::CAPACITY - 1) begin : g_tail
                assign right_d = '0;
            end else begin : g_mid_r
                assign right_d = cell_data[i+1];
            end
            plc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .idx        (plc_pkg::ADDR_W'(i)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i]),
                .hit_data   (hit_data[i])
            );
        end
    endgenerate

    plc_gather u_gather (
        .aclk     (aclk),
        .en       (exec),
        .hit_data (hit_data),
        .result   (gather_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_total_reg, m_item_reg, m_status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= plc_pkg::CNT_W'(plc_pkg::CAPACITY))
        else $error("element count above capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == S_EXEC)
        else $error("accepted command did not execute");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && cmd_ins_reg) |=> count_reg == $past(count_reg) + plc_pkg::CNT_W'(1))
        else $error("insert did not grow the list");

    a_ins_rem_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd_ins_reg && (cmd_rem_reg || cmd_rd_reg)))
        else $error("insert decoded together with remove or read");

    a_zero_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_status_reg != plc_pkg::ST_DONE) |-> m_item_reg == '0)
        else $error("result item set on a failed command");
`endif

endmodule
`default_nettype wire
